>>> rtl/affine_2x3_inverse_top_defines.svh
// ----------------------------------------------------------------------------
// affine_2x3_inverse_top_defines
// Assertion macros for the affine inverse block. Each macro takes a label,
// the clock, the active-low reset and two expressions.
// ----------------------------------------------------------------------------
`ifndef AFFINE_2X3_INVERSE_TOP_DEFINES_SVH
`define AFFINE_2X3_INVERSE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define AFI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("affine inverse: assertion failed");
`define AFI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("affine inverse: assertion failed");
`else
`define AFI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AFI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/afi_pkg.sv
// ----------------------------------------------------------------------------
// afi_pkg
// Shared constants, types and helpers for the affine transform inverse.
// ----------------------------------------------------------------------------
package afi_pkg;

    localparam int IO_BITS   = 32;
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    // Products and determinant are exact at double width.
    localparam int PROD_BITS = 2 * WORD_BITS;
    // Quotient bits produced by the divider.
    localparam int QUO_BITS  = WORD_BITS;
    // Dividend width, wide enough for either shift.
    localparam int DVD_BITS  = 3 * WORD_BITS + 2 * FRAC_BITS;
    localparam int HI_BITS   = DVD_BITS - QUO_BITS;
    localparam int SH_ELEM   = 2 * FRAC_BITS;
    localparam int SH_TRANS  = FRAC_BITS;
    // Tag line depth: two front stages plus the divider latency.
    localparam int TAG_DEPTH = QUO_BITS + 5;

    localparam logic [WORD_BITS-1:0] LIM_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] LIM_POS = {1'b0, {(WORD_BITS-1){1'b1}}};

    typedef struct packed {
        logic signed [PROD_BITS-1:0] det;
        logic signed [PROD_BITS-1:0] nx;
        logic signed [PROD_BITS-1:0] ny;
        logic signed [PROD_BITS-1:0] a;
        logic signed [PROD_BITS-1:0] b;
        logic signed [PROD_BITS-1:0] c;
        logic signed [PROD_BITS-1:0] d;
    } t_front;

    typedef logic [5:0][IO_BITS-1:0] t_raw;

    // Keep the low word bits of an input as a signed word.
    function automatic logic signed [WORD_BITS-1:0] sx_word(input logic [IO_BITS-1:0] x);
        sx_word = signed'(x[WORD_BITS-1:0]);
    endfunction

endpackage

>>> rtl/afi_front.sv
// ----------------------------------------------------------------------------
// afi_front
// Products, determinant and translation numerators over two register stages.
// ----------------------------------------------------------------------------
module afi_front (
    input  logic                                i_clk,
    input  logic signed [afi_pkg::WORD_BITS-1:0] i_a,
    input  logic signed [afi_pkg::WORD_BITS-1:0] i_b,
    input  logic signed [afi_pkg::WORD_BITS-1:0] i_c,
    input  logic signed [afi_pkg::WORD_BITS-1:0] i_d,
    input  logic signed [afi_pkg::WORD_BITS-1:0] i_tx,
    input  logic signed [afi_pkg::WORD_BITS-1:0] i_ty,
    output afi_pkg::t_front                     o_front
);
    import afi_pkg::*;

    logic signed [PROD_BITS-1:0] r_ad, r_bc, r_cty, r_dtx, r_btx, r_aty;
    logic signed [PROD_BITS-1:0] r_a, r_b, r_c, r_d;
    t_front                      r_front;

    // First stage: six signed products, one multiplier each.
    always_ff @(posedge i_clk) begin
        r_ad  <= PROD_BITS'(i_a) * PROD_BITS'(i_d);
        r_bc  <= PROD_BITS'(i_b) * PROD_BITS'(i_c);
        r_cty <= PROD_BITS'(i_c) * PROD_BITS'(i_ty);
        r_dtx <= PROD_BITS'(i_d) * PROD_BITS'(i_tx);
        r_btx <= PROD_BITS'(i_b) * PROD_BITS'(i_tx);
        r_aty <= PROD_BITS'(i_a) * PROD_BITS'(i_ty);
        r_a   <= PROD_BITS'(i_a);
        r_b   <= PROD_BITS'(i_b);
        r_c   <= PROD_BITS'(i_c);
        r_d   <= PROD_BITS'(i_d);
    end

    // Second stage: the differences, which always fit the double width.
    always_ff @(posedge i_clk) begin
        r_front.det <= r_ad - r_bc;
        r_front.nx  <= r_cty - r_dtx;
        r_front.ny  <= r_btx - r_aty;
        r_front.a   <= r_a;
        r_front.b   <= r_b;
        r_front.c   <= r_c;
        r_front.d   <= r_d;
    end

    assign o_front = r_front;

endmodule

>>> rtl/afi_div.sv
// ----------------------------------------------------------------------------
// afi_div
// Pipelined restoring divider: one quotient bit per stage, saturating output.
// ----------------------------------------------------------------------------
module afi_div (
    input  logic                                 i_clk,
    input  logic signed [afi_pkg::PROD_BITS-1:0] i_num,
    input  logic                                 i_flip,
    input  logic signed [afi_pkg::PROD_BITS-1:0] i_den,
    input  logic                                 i_trans,
    output logic        [afi_pkg::WORD_BITS-1:0] o_quo,
    output logic                                 o_sat
);
    import afi_pkg::*;

    logic [PROD_BITS-1:0] r_nmag, r_dmag0;
    logic                 r_neg0;

    logic [PROD_BITS-1:0] r_rem [0:QUO_BITS];
    logic [QUO_BITS-1:0]  r_low [0:QUO_BITS];
    logic [QUO_BITS-1:0]  r_q   [0:QUO_BITS];
    logic [PROD_BITS-1:0] r_dm  [0:QUO_BITS];
    logic                 r_ng  [0:QUO_BITS];
    logic                 r_bg  [0:QUO_BITS];

    logic [PROD_BITS-1:0] n_rem [1:QUO_BITS];
    logic [QUO_BITS-1:0]  n_low [1:QUO_BITS];
    logic [QUO_BITS-1:0]  n_q   [1:QUO_BITS];

    logic [DVD_BITS-1:0]  w_dvd;
    logic [HI_BITS-1:0]   w_hi;
    logic [PROD_BITS:0]   w_t    [0:QUO_BITS-1];
    logic [PROD_BITS:0]   w_diff [0:QUO_BITS-1];
    logic                 w_ge   [0:QUO_BITS-1];
    logic [WORD_BITS-1:0] w_lim, w_qq, r_quo;
    logic                 w_sat, r_sat;

    // Magnitudes and result sign.
    always_ff @(posedge i_clk) begin
        r_nmag  <= i_num[PROD_BITS-1] ? PROD_BITS'(-i_num) : PROD_BITS'(i_num);
        r_dmag0 <= i_den[PROD_BITS-1] ? PROD_BITS'(-i_den) : PROD_BITS'(i_den);
        r_neg0  <= (i_num != '0) && (i_num[PROD_BITS-1] ^ i_flip ^ i_den[PROD_BITS-1]);
    end

    // Align the dividend and test whether the quotient overflows the word.
    always_comb begin
        if (i_trans) begin
            w_dvd = DVD_BITS'(r_nmag) << SH_TRANS;
        end else begin
            w_dvd = DVD_BITS'(r_nmag) << SH_ELEM;
        end
        w_hi = w_dvd[DVD_BITS-1:QUO_BITS];
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_hi[PROD_BITS-1:0];
        r_low[0] <= w_dvd[QUO_BITS-1:0];
        r_q[0]   <= '0;
        r_dm[0]  <= r_dmag0;
        r_ng[0]  <= r_neg0;
        r_bg[0]  <= (w_hi >= HI_BITS'(r_dmag0));
    end

    // One compare and subtract per stage.
    always_comb begin
        for (int j = 0; j < QUO_BITS; j++) begin
            w_t[j]      = {r_rem[j], r_low[j][QUO_BITS-1]};
            w_diff[j]   = w_t[j] - {1'b0, r_dm[j]};
            w_ge[j]     = (w_t[j] >= {1'b0, r_dm[j]});
            n_rem[j+1]  = w_ge[j] ? w_diff[j][PROD_BITS-1:0] : w_t[j][PROD_BITS-1:0];
            n_q[j+1]    = {r_q[j][QUO_BITS-2:0], w_ge[j]};
            n_low[j+1]  = {r_low[j][QUO_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 1; j <= QUO_BITS; j++) begin
            r_rem[j] <= n_rem[j];
            r_low[j] <= n_low[j];
            r_q[j]   <= n_q[j];
            r_dm[j]  <= r_dm[j-1];
            r_ng[j]  <= r_ng[j-1];
            r_bg[j]  <= r_bg[j-1];
        end
    end

    // Clamp to the signed word range and apply the sign.
    always_comb begin
        w_lim = r_ng[QUO_BITS] ? LIM_NEG : LIM_POS;
        w_sat = r_bg[QUO_BITS] || (r_q[QUO_BITS] > w_lim);
        w_qq  = w_sat ? w_lim : r_q[QUO_BITS];
    end

    always_ff @(posedge i_clk) begin
        r_quo <= r_ng[QUO_BITS] ? WORD_BITS'(-w_qq) : w_qq;
        r_sat <= w_sat;
    end

    assign o_quo = r_quo;
    assign o_sat = r_sat;

endmodule

>>> rtl/affine_2x3_inverse_top.sv
// ----------------------------------------------------------------------------
// affine_2x3_inverse_top
// Inverts a 2D affine transform in signed fixed point, one matrix per cycle.
//
//   Channel   Direction  Handshake         Fields
//   command   in         start, busy       i_in_a .. i_in_ty
//   result    out        o_valid strobe    o_out_a .. o_out_ty, flags
//
// A matrix is taken in every cycle; busy stays low.
// Each result is registered through the front stages, the one-bit-per-stage
// divider pipelines and the output register, in that order.
// Reset clears the valid line only; the receiver cannot stall the output.
// ----------------------------------------------------------------------------
`include "affine_2x3_inverse_top_defines.svh"

module affine_2x3_inverse_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [afi_pkg::IO_BITS-1:0] i_in_a,
    input  logic signed [afi_pkg::IO_BITS-1:0] i_in_b,
    input  logic signed [afi_pkg::IO_BITS-1:0] i_in_c,
    input  logic signed [afi_pkg::IO_BITS-1:0] i_in_d,
    input  logic signed [afi_pkg::IO_BITS-1:0] i_in_tx,
    input  logic signed [afi_pkg::IO_BITS-1:0] i_in_ty,
    output logic                              o_valid,
    output logic signed [afi_pkg::IO_BITS-1:0] o_out_a,
    output logic signed [afi_pkg::IO_BITS-1:0] o_out_b,
    output logic signed [afi_pkg::IO_BITS-1:0] o_out_c,
    output logic signed [afi_pkg::IO_BITS-1:0] o_out_d,
    output logic signed [afi_pkg::IO_BITS-1:0] o_out_tx,
    output logic signed [afi_pkg::IO_BITS-1:0] o_out_ty,
    output logic                              o_singular,
    output logic                              o_saturated
);
    import afi_pkg::*;

    t_front               w_front;
    logic [WORD_BITS-1:0] w_quo [0:5];
    logic [5:0]           w_sat;

    logic                 r_vld [0:TAG_DEPTH-1];
    logic                 r_sng [0:TAG_DEPTH-1];
    t_raw                 r_raw [0:TAG_DEPTH-1];

    logic                 r_o_valid, r_o_sing, r_o_sat;
    t_raw                 r_o_data;
    logic                 w_take;

    assign busy   = 1'b0;
    assign w_take = start && !busy;

    // Products and numerators.
    afi_front u_front (
        .i_clk   (i_clk),
        .i_a     (sx_word(i_in_a)),
        .i_b     (sx_word(i_in_b)),
        .i_c     (sx_word(i_in_c)),
        .i_d     (sx_word(i_in_d)),
        .i_tx    (sx_word(i_in_tx)),
        .i_ty    (sx_word(i_in_ty)),
        .o_front (w_front)
    );

    // Six divider lanes over the shared determinant.
    afi_div u_div_a (.i_clk(i_clk), .i_num(w_front.d), .i_flip(1'b0), .i_den(w_front.det),
                     .i_trans(1'b0), .o_quo(w_quo[0]), .o_sat(w_sat[0]));
    afi_div u_div_b (.i_clk(i_clk), .i_num(w_front.b), .i_flip(1'b1), .i_den(w_front.det),
                     .i_trans(1'b0), .o_quo(w_quo[1]), .o_sat(w_sat[1]));
    afi_div u_div_c (.i_clk(i_clk), .i_num(w_front.c), .i_flip(1'b1), .i_den(w_front.det),
                     .i_trans(1'b0), .o_quo(w_quo[2]), .o_sat(w_sat[2]));
    afi_div u_div_d (.i_clk(i_clk), .i_num(w_front.a), .i_flip(1'b0), .i_den(w_front.det),
                     .i_trans(1'b0), .o_quo(w_quo[3]), .o_sat(w_sat[3]));
    afi_div u_div_x (.i_clk(i_clk), .i_num(w_front.nx), .i_flip(1'b0), .i_den(w_front.det),
                     .i_trans(1'b1), .o_quo(w_quo[4]), .o_sat(w_sat[4]));
    afi_div u_div_y (.i_clk(i_clk), .i_num(w_front.ny), .i_flip(1'b0), .i_den(w_front.det),
                     .i_trans(1'b1), .o_quo(w_quo[5]), .o_sat(w_sat[5]));

    // Valid bits travel alongside the data; reset clears them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAG_DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else begin
            r_vld[0] <= w_take;
            for (int k = 1; k < TAG_DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_o_valid <= r_vld[TAG_DEPTH-1];
        end
    end

    // Raw inputs and the singular flag, which joins once the determinant exists.
    always_ff @(posedge i_clk) begin
        r_raw[0] <= {i_in_ty, i_in_tx, i_in_d, i_in_c, i_in_b, i_in_a};
        r_sng[0] <= 1'b0;
        for (int k = 1; k < TAG_DEPTH; k++) begin
            r_raw[k] <= r_raw[k-1];
            r_sng[k] <= (k == 2) ? (w_front.det == '0) : r_sng[k-1];
        end
    end

    // Output register: pass the inputs through when the matrix is singular.
    always_ff @(posedge i_clk) begin
        r_o_sing <= r_sng[TAG_DEPTH-1];
        r_o_sat  <= !r_sng[TAG_DEPTH-1] && (|w_sat);
        for (int f = 0; f < 6; f++) begin
            r_o_data[f] <= r_sng[TAG_DEPTH-1] ? r_raw[TAG_DEPTH-1][f]
                                              : IO_BITS'(signed'(w_quo[f]));
        end
    end

    assign o_valid     = r_o_valid;
    assign o_singular  = r_o_sing;
    assign o_saturated = r_o_sat;
    assign o_out_a     = r_o_data[0];
    assign o_out_b     = r_o_data[1];
    assign o_out_c     = r_o_data[2];
    assign o_out_d     = r_o_data[3];
    assign o_out_tx    = r_o_data[4];
    assign o_out_ty    = r_o_data[5];

    // Checks on latency, flag exclusion and the singular pass-through.
    `AFI_ASSERT_IMP(a_latency, i_clk, i_rst_n, o_valid, $past(start, TAG_DEPTH + 1))
    `AFI_ASSERT_IMP(a_flags, i_clk, i_rst_n, o_valid && o_singular, !o_saturated)
    `AFI_ASSERT_IMP(a_passthru, i_clk, i_rst_n, o_valid && o_singular,
                    o_out_a == $past(i_in_a, TAG_DEPTH + 1))

endmodule
